// ----- hw/rtl/dcpid_pkg.sv -----
`default_nettype none

package dcpid_pkg;

    // gain register defaults, gain times 1000
    localparam logic [15:0] KP_NORMAL_RST = 16'd1100;
    localparam logic [15:0] KI_NORMAL_RST = 16'd17;
    localparam logic [15:0] KD_NORMAL_RST = 16'd28;
    localparam logic [15:0] KP_SENSOR_RST = 16'd15000;
    localparam logic [15:0] KI_SENSOR_RST = 16'd160;
    localparam logic [15:0] KD_SENSOR_RST = 16'd80;

    // configuration register map
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KP_NORMAL = 3'd0,
        REG_KI_NORMAL = 3'd1,
        REG_KD_NORMAL = 3'd2,
        REG_KP_SENSOR = 3'd3,
        REG_KI_SENSOR = 3'd4,
        REG_KD_SENSOR = 3'd5
    } cfg_reg_t;

    // one gain set
    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } gains_t;

    // divide by 1000 is a shift by 3 followed by a divide by 125
    localparam logic [6:0]  DIV_CHUNK = 7'd125;
    // floor(2^19 / 125) and floor(2^26 / 125)
    localparam logic [12:0] RECIP_HI  = 13'd4194;
    localparam logic [19:0] RECIP_LO  = 20'd536870;

    // |sum| at or above 2^31 * 1000 always saturates the drive value
    localparam logic [63:0] SAT_LIMIT = 64'd2147483648000;

    localparam logic [31:0] DRIVE_MAX = 32'h7fff_ffff;
    localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// ----- hw/rtl/dcpid_gain_regs.sv -----
`default_nettype none

module dcpid_gain_regs
    import dcpid_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output gains_t                      gains_normal,
    output gains_t                      gains_sensor
);

    gains_t normal_reg;
    gains_t sensor_reg;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg.kp <= KP_NORMAL_RST;
            normal_reg.ki <= KI_NORMAL_RST;
            normal_reg.kd <= KD_NORMAL_RST;
            sensor_reg.kp <= KP_SENSOR_RST;
            sensor_reg.ki <= KI_SENSOR_RST;
            sensor_reg.kd <= KD_SENSOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KP_NORMAL: normal_reg.kp <= cfg_data;
                REG_KI_NORMAL: normal_reg.ki <= cfg_data;
                REG_KD_NORMAL: normal_reg.kd <= cfg_data;
                REG_KP_SENSOR: sensor_reg.kp <= cfg_data;
                REG_KI_SENSOR: sensor_reg.ki <= cfg_data;
                REG_KD_SENSOR: sensor_reg.kd <= cfg_data;
                default: ;
            endcase
        end
    end

    assign gains_normal = normal_reg;
    assign gains_sensor = sensor_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dcpid_state.sv -----
`default_nettype none

module dcpid_state
    import dcpid_pkg::*;
#(
    parameter int ERROR_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         clear,
    input  wire logic                         side,
    input  wire logic                         gain_set,
    input  wire logic signed [ERROR_BITS-1:0] error_sample,
    input  wire gains_t                       gains_normal,
    input  wire gains_t                       gains_sensor,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [ERROR_BITS-1:0]      err_out,
    output logic signed [31:0]                integ_out,
    output logic signed [ERROR_BITS:0]        deriv_out,
    output gains_t                            gains_out
);

    logic signed [ERROR_BITS-1:0] prev_err_reg [2];
    logic signed [31:0]           integ_reg [2];
    logic                         valid_reg;

    logic signed [ERROR_BITS-1:0] err_reg;
    logic signed [31:0]           integ_out_reg;
    logic signed [ERROR_BITS:0]   deriv_reg;
    gains_t                       gains_reg;

    logic                         accept;
    logic signed [ERROR_BITS-1:0] prev_sel;
    logic signed [31:0]           integ_sel;
    logic signed [32:0]           integ_wide;
    logic signed [31:0]           integ_next;
    logic signed [ERROR_BITS:0]   deriv_next;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // saturating integral and derivative for the selected side
    always_comb
    begin
        prev_sel   = prev_err_reg[side];
        integ_sel  = integ_reg[side];
        integ_wide = 33'(integ_sel) + 33'(error_sample);
        if (integ_wide[32] != integ_wide[31])
        begin
            integ_next = integ_wide[32] ? $signed(DRIVE_MIN) : $signed(DRIVE_MAX);
        end
        else
        begin
            integ_next = integ_wide[31:0];
        end
        deriv_next = (ERROR_BITS + 1)'(error_sample) - (ERROR_BITS + 1)'(prev_sel);
    end

    // per-side controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg[0] <= '0;
            prev_err_reg[1] <= '0;
            integ_reg[0]    <= '0;
            integ_reg[1]    <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                if (clear)
                begin
                    prev_err_reg[0] <= '0;
                    prev_err_reg[1] <= '0;
                    integ_reg[0]    <= '0;
                    integ_reg[1]    <= '0;
                end
                else
                begin
                    prev_err_reg[side] <= error_sample;
                    integ_reg[side]    <= integ_next;
                end
            end
        end
    end

    // stage payload, all zero for a clear so the result is zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (clear)
            begin
                err_reg       <= '0;
                integ_out_reg <= '0;
                deriv_reg     <= '0;
            end
            else
            begin
                err_reg       <= error_sample;
                integ_out_reg <= integ_next;
                deriv_reg     <= deriv_next;
            end
            gains_reg <= gain_set ? gains_sensor : gains_normal;
        end
    end

    assign out_valid = valid_reg;
    assign err_out   = err_reg;
    assign integ_out = integ_out_reg;
    assign deriv_out = deriv_reg;
    assign gains_out = gains_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dcpid_mac.sv -----
`default_nettype none

module dcpid_mac
    import dcpid_pkg::*;
#(
    parameter int ERROR_BITS = 16,
    parameter int SUM_W      = 50
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [ERROR_BITS-1:0] err_in,
    input  wire logic signed [31:0]           integ_in,
    input  wire logic signed [ERROR_BITS:0]   deriv_in,
    input  wire gains_t                       gains_in,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [SUM_W-1:0]           sum_out
);

    localparam int PP_W = ERROR_BITS + 17;
    localparam int PI_W = 49;
    localparam int PD_W = ERROR_BITS + 18;

    logic                   prod_valid_reg;
    logic                   sum_valid_reg;
    logic                   prod_ready;
    logic                   sum_ready;

    logic signed [PP_W-1:0] pp_reg;
    logic signed [PI_W-1:0] pi_reg;
    logic signed [PD_W-1:0] pd_reg;
    logic signed [PP_W-1:0] pp_next;
    logic signed [PI_W-1:0] pi_next;
    logic signed [PD_W-1:0] pd_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;

    assign sum_ready  = !sum_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || sum_ready;
    assign in_ready   = prod_ready;

    // three gain products
    always_comb
    begin
        pp_next = $signed({1'b0, gains_in.kp}) * err_in;
        pi_next = $signed({1'b0, gains_in.ki}) * integ_in;
        pd_next = $signed({1'b0, gains_in.kd}) * deriv_in;
    end

    // wide sum of the products
    assign sum_next = SUM_W'(pp_reg) + SUM_W'(pi_reg) + SUM_W'(pd_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && in_valid)
        begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
        if (sum_ready && prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sum_out   = sum_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dcpid_div.sv -----
`default_nettype none

module dcpid_div
    import dcpid_pkg::*;
#(
    parameter int SUM_W = 50
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [SUM_W-1:0] sum_in,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [31:0]                 drive
);

    // stage valids: magnitude, high estimate, high digit, low estimate, result
    logic [4:0]  valid_reg;
    logic [4:0]  ready;

    // magnitude stage
    logic             neg_a_reg;
    logic             big_a_reg;
    logic [37:0]      y_reg;
    logic [SUM_W-1:0] mag;

    // high quotient estimate stage
    logic        neg_b_reg;
    logic        big_b_reg;
    logic [12:0] q1e_reg;
    logic [18:0] h_reg;
    logic [18:0] l_b_reg;
    logic [31:0] hi_prod;

    // high quotient digit stage
    logic        neg_c_reg;
    logic        big_c_reg;
    logic [12:0] q1_reg;
    logic [6:0]  r1_reg;
    logic [18:0] l_c_reg;
    logic [19:0] hi_back;
    logic [7:0]  hi_rem;
    logic [12:0] q1_next;
    logic [6:0]  r1_next;

    // low quotient estimate stage
    logic        neg_d_reg;
    logic        big_d_reg;
    logic [12:0] q1_d_reg;
    logic [19:0] q2e_reg;
    logic [25:0] v_reg;
    logic [25:0] v_next;
    logic [45:0] lo_prod;

    // result stage
    logic [31:0] drive_reg;
    logic [26:0] lo_back;
    logic [7:0]  lo_rem;
    logic [19:0] q2;
    logic [31:0] q_mag;
    logic [31:0] drive_next;

    // stall chain from the result register backward
    assign ready[4] = !valid_reg[4] || out_ready;
    assign ready[3] = !valid_reg[3] || ready[4];
    assign ready[2] = !valid_reg[2] || ready[3];
    assign ready[1] = !valid_reg[1] || ready[2];
    assign ready[0] = !valid_reg[0] || ready[1];
    assign in_ready = ready[0];

    // magnitude, sign and early saturation test
    assign mag = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : sum_in;

    // high part estimate: h * floor(2^19 / 125) >> 19
    assign hi_prod = 32'(y_reg[37:19]) * 32'(RECIP_HI);

    // high part correction, estimate is low by at most one
    always_comb
    begin
        hi_back = 20'(q1e_reg) * 20'(DIV_CHUNK);
        hi_rem  = 8'(20'(h_reg) - hi_back);
        if (hi_rem >= 8'(DIV_CHUNK))
        begin
            q1_next = q1e_reg + 13'd1;
            r1_next = 7'(hi_rem - 8'(DIV_CHUNK));
        end
        else
        begin
            q1_next = q1e_reg;
            r1_next = hi_rem[6:0];
        end
    end

    // low part estimate on remainder and low bits
    assign v_next  = {r1_reg, l_c_reg};
    assign lo_prod = 46'(v_next) * 46'(RECIP_LO);

    // low part correction, merge, saturate and apply the sign
    always_comb
    begin
        lo_back = 27'(q2e_reg) * 27'(DIV_CHUNK);
        lo_rem  = 8'(27'(v_reg) - lo_back);
        q2      = (lo_rem >= 8'(DIV_CHUNK)) ? q2e_reg + 20'd1 : q2e_reg;
        q_mag   = {q1_d_reg, 19'd0} + 32'(q2);
        if (big_d_reg)
        begin
            drive_next = neg_d_reg ? DRIVE_MIN : DRIVE_MAX;
        end
        else
        begin
            drive_next = neg_d_reg ? -q_mag : q_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= in_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
            if (ready[3]) valid_reg[3] <= valid_reg[2];
            if (ready[4]) valid_reg[4] <= valid_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            neg_a_reg <= sum_in[SUM_W-1];
            big_a_reg <= mag >= SUM_W'(SAT_LIMIT);
            y_reg     <= mag[40:3];
        end
        if (ready[1] && valid_reg[0])
        begin
            neg_b_reg <= neg_a_reg;
            big_b_reg <= big_a_reg;
            q1e_reg   <= hi_prod[31:19];
            h_reg     <= y_reg[37:19];
            l_b_reg   <= y_reg[18:0];
        end
        if (ready[2] && valid_reg[1])
        begin
            neg_c_reg <= neg_b_reg;
            big_c_reg <= big_b_reg;
            q1_reg    <= q1_next;
            r1_reg    <= r1_next;
            l_c_reg   <= l_b_reg;
        end
        if (ready[3] && valid_reg[2])
        begin
            neg_d_reg <= neg_c_reg;
            big_d_reg <= big_c_reg;
            q1_d_reg  <= q1_reg;
            q2e_reg   <= lo_prod[45:26];
            v_reg     <= v_next;
        end
        if (ready[4] && valid_reg[3])
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = valid_reg[4];
    assign drive     = drive_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/dual_channel_pid_controller_core.sv -----
// path: a result passes the state, product and sum registers, then the divider's stage registers
// throughput: one transaction per cycle; the block stalls only when the
// result register is full and the output side does not take it
// reset: gains return to their defaults, both sides' integral and previous
// error clear to zero, and the pipeline empties
`default_nettype none

module dual_channel_pid_controller_core
    import dcpid_pkg::*;
#(
    parameter int ERROR_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // error_sample
    input  wire logic [((ERROR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind, side, gain_set
    input  wire logic [2:0]             s_axis_tuser,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // drive
    output logic [31:0]                 m_axis_tdata,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PROD_W = (ERROR_BITS + 18 > 48) ? ERROR_BITS + 18 : 48;
    localparam int SUM_W  = PROD_W + 2;

    gains_t gains_normal;
    gains_t gains_sensor;
    gains_t gains_st;

    logic                         st_valid;
    logic                         st_ready;
    logic signed [ERROR_BITS-1:0] err_st;
    logic signed [31:0]           integ_st;
    logic signed [ERROR_BITS:0]   deriv_st;

    logic                         sum_valid;
    logic                         sum_ready;
    logic signed [SUM_W-1:0]      sum;

    // gain registers
    dcpid_gain_regs u_gain_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .gains_normal (gains_normal),
        .gains_sensor (gains_sensor)
    );

    // per-side state update and input register
    dcpid_state #(
        .ERROR_BITS (ERROR_BITS)
    ) u_state (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .clear        (s_axis_tuser[0]),
        .side         (s_axis_tuser[1]),
        .gain_set     (s_axis_tuser[2]),
        .error_sample ($signed(s_axis_tdata[ERROR_BITS-1:0])),
        .gains_normal (gains_normal),
        .gains_sensor (gains_sensor),
        .out_valid    (st_valid),
        .out_ready    (st_ready),
        .err_out      (err_st),
        .integ_out    (integ_st),
        .deriv_out    (deriv_st),
        .gains_out    (gains_st)
    );

    // products and wide sum
    dcpid_mac #(
        .ERROR_BITS (ERROR_BITS),
        .SUM_W      (SUM_W)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid),
        .in_ready  (st_ready),
        .err_in    (err_st),
        .integ_in  (integ_st),
        .deriv_in  (deriv_st),
        .gains_in  (gains_st),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .sum_out   (sum)
    );

    // divide by 1000 toward zero and saturate
    dcpid_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .sum_in    (sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .drive     (m_axis_tdata)
    );

endmodule

`default_nettype wire
